// File: hdl/ptsched_pkg.sv
// Shared types and constants for the preemptive three-level task scheduler.
// No dependencies; imported by the scheduler top level.
package ptsched_pkg;

    // Default configuration.
    localparam int PTS_QUEUE_DEPTH = 4;
    localparam int PTS_ID_WIDTH    = 8;

    // Number of priority levels, level 0 being the most urgent.
    localparam int PTS_LEVELS = 3;

    // Level code that carries no meaning on an arrival.
    localparam logic [1:0] PTS_LEVEL_NONE = 2'd3;

    // Word layouts on the stream ports.
    localparam int PTS_S_TDATA_W = 16;
    localparam int PTS_M_TDATA_W = 24;
    localparam int PTS_PORT_ID_W = 8;

    // What an input word asks for.
    typedef enum logic {
        KIND_ARRIVAL = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    // Where the next running task came from.
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_FIFO,
        SRC_STACK
    } sel_src_t;

endpackage

// File: hdl/preemptive_three_level_task_scheduler.sv
// Top level of the preemptive three-level task scheduler.
// Depends on ptsched_pkg and ptsched_ram.
//
// The scheduler takes one word per clock cycle while its result register is free or
// draining, and answers each with one registered result word; the whole decision (store,
// preemption check, pick of the next task) is settled combinationally between the input
// handshake and the result register. Each level FIFO and the preemption stack sit in small
// memories whose read port always holds the current head or top, so back-to-back words
// never wait. An input word is taken whenever the result register is empty or being
// drained in the same cycle. There is no clearing pass after reset: level counts, stack
// count, running slot and resume flag are cleared at once.
module preemptive_three_level_task_scheduler
    import ptsched_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTS_QUEUE_DEPTH,
    parameter int ID_WIDTH    = PTS_ID_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // priority_req [1:0], task_id [9:2], zero fill [15:10]
    input  logic [PTS_S_TDATA_W-1:0] s_tdata,
    // kind [0]
    input  logic [0:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // accepted [0], completed_valid [1], completed_id [9:2], running_valid [10],
    // running_id [18:11], running_priority [20:19], resume_flag [21], zero fill [23:22]
    output logic [PTS_M_TDATA_W-1:0] m_tdata
);

    localparam int QIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUMW  = CW + 1;
    localparam int SD    = 3 * QUEUE_DEPTH;
    localparam int SIW   = $clog2(SD);
    localparam int SCW   = $clog2(SD + 1);
    localparam int TW    = $clog2(6 * QUEUE_DEPTH + 1);
    localparam int SEW   = 2 + ID_WIDTH;

    // Level FIFO bookkeeping.
    logic [QIW-1:0]      head_reg   [PTS_LEVELS];
    logic [QIW-1:0]      head_next  [PTS_LEVELS];
    logic [CW-1:0]       count_reg  [PTS_LEVELS];
    logic [CW-1:0]       count_next [PTS_LEVELS];
    logic [QIW-1:0]      head_inc   [PTS_LEVELS];
    logic [SUMW-1:0]     tail_sum   [PTS_LEVELS];
    logic [QIW-1:0]      tail_addr  [PTS_LEVELS];
    logic [QIW-1:0]      fifo_raddr [PTS_LEVELS];
    logic [ID_WIDTH-1:0] fifo_rdata [PTS_LEVELS];
    logic [ID_WIDTH-1:0] head_val   [PTS_LEVELS];
    logic                wr_lvl     [PTS_LEVELS];
    logic                pop_lvl    [PTS_LEVELS];
    logic                avail_lvl  [PTS_LEVELS];

    // Preemption stack bookkeeping.
    logic [SCW-1:0] stack_cnt_reg;
    logic [SCW-1:0] stack_cnt_next;
    logic [SCW-1:0] stack_cnt_pushed;
    logic [SCW-1:0] stack_top_cnt;
    logic [SIW-1:0] stack_raddr;
    logic [SIW-1:0] stack_waddr;
    logic [SEW-1:0] stack_wdata;
    logic [SEW-1:0] stack_rdata;
    logic [SEW-1:0] stack_top;
    logic           stack_push;
    logic           stack_pop;

    // Running slot and resume flag.
    logic                run_valid_reg;
    logic                run_valid_next;
    logic [ID_WIDTH-1:0] run_id_reg;
    logic [ID_WIDTH-1:0] run_id_next;
    logic [1:0]          run_prio_reg;
    logic [1:0]          run_prio_next;
    logic                resume_reg;
    logic                resume_next;

    // Input word fields.
    logic                  s_fire;
    kind_t                 in_kind;
    logic [1:0]            in_prio;
    logic [PTS_PORT_ID_W-1:0] in_id_port;
    logic [ID_WIDTH+PTS_PORT_ID_W-1:0] in_id_ext;
    logic [ID_WIDTH-1:0]   in_id;

    // Decision signals.
    logic [TW-1:0] total;
    logic          arr_valid;
    logic          do_sel;
    sel_src_t      sel_src;
    logic          completed_valid;
    logic [ID_WIDTH-1:0] completed_id;

    // Result register.
    logic                     m_valid_reg;
    logic [PTS_M_TDATA_W-1:0] m_data_reg;
    logic [PTS_M_TDATA_W-1:0] m_data_next;
    logic [ID_WIDTH+PTS_PORT_ID_W-1:0] comp_id_ext;
    logic [ID_WIDTH+PTS_PORT_ID_W-1:0] run_id_ext;
    logic [PTS_PORT_ID_W-1:0] comp_id_port;
    logic [PTS_PORT_ID_W-1:0] run_id_port;
    logic [1:0]               run_prio_port;

    // Handshake: a new word is taken while the result register is free or draining.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Unpack the input word and size the identifier to ID_WIDTH.
    assign in_kind    = kind_t'(s_tuser[0]);
    assign in_prio    = s_tdata[1:0];
    assign in_id_port = s_tdata[9:2];
    assign in_id_ext  = {{ID_WIDTH{1'b0}}, in_id_port};
    assign in_id      = in_id_ext[ID_WIDTH-1:0];

    // Storage for the three level FIFOs.
    for (genvar g = 0; g < PTS_LEVELS; g++) begin : g_fifo
        ptsched_ram #(
            .DEPTH (QUEUE_DEPTH),
            .WIDTH (ID_WIDTH)
        ) u_fifo_ram (
            .aclk  (aclk),
            .we    (s_fire && wr_lvl[g]),
            .waddr (tail_addr[g]),
            .wdata (in_id),
            .raddr (fifo_raddr[g]),
            .rdata (fifo_rdata[g])
        );
    end

    // Storage for the preemption stack, entries are {priority, id}.
    ptsched_ram #(
        .DEPTH (SD),
        .WIDTH (SEW)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (s_fire && stack_push),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Store, preemption check and selection of the next running task.
    always_comb begin
        total = TW'(stack_cnt_reg);
        for (int l = 0; l < PTS_LEVELS; l++) begin
            total = total + TW'(count_reg[l]);
        end

        arr_valid = (in_kind == KIND_ARRIVAL) && (in_prio != PTS_LEVEL_NONE)
                    && (total < TW'(SD));

        // Arrival write position in each level.
        for (int l = 0; l < PTS_LEVELS; l++) begin
            wr_lvl[l]   = arr_valid && (in_prio == 2'(l))
                          && (count_reg[l] < CW'(QUEUE_DEPTH));
            tail_sum[l] = SUMW'(head_reg[l]) + SUMW'(count_reg[l]);
            if (tail_sum[l] >= SUMW'(QUEUE_DEPTH)) begin
                tail_sum[l] = tail_sum[l] - SUMW'(QUEUE_DEPTH);
            end
            tail_addr[l] = tail_sum[l][QIW-1:0];
            avail_lvl[l] = (count_reg[l] != '0) || wr_lvl[l];
            head_val[l]  = (count_reg[l] == '0) ? in_id : fifo_rdata[l];
        end

        // Preemption check on an arrival, or completion on a tick.
        do_sel          = 1'b0;
        stack_push      = 1'b0;
        completed_valid = 1'b0;
        completed_id    = '0;
        if (in_kind == KIND_TICK) begin
            do_sel          = 1'b1;
            completed_valid = run_valid_reg;
            completed_id    = run_valid_reg ? run_id_reg : '0;
        end else if (arr_valid && !resume_reg) begin
            if (!run_valid_reg) begin
                do_sel = 1'b1;
            end else if (run_prio_reg > in_prio) begin
                do_sel     = 1'b1;
                stack_push = (stack_cnt_reg < SCW'(SD));
            end
        end

        stack_wdata      = {run_prio_reg, run_id_reg};
        stack_waddr      = stack_cnt_reg[SIW-1:0];
        stack_cnt_pushed = stack_cnt_reg + SCW'(stack_push);
        stack_top        = stack_push ? stack_wdata : stack_rdata;

        // Highest non-empty level first, then the stack top.
        sel_src = SRC_NONE;
        for (int l = 0; l < PTS_LEVELS; l++) begin
            pop_lvl[l] = 1'b0;
        end
        if (do_sel) begin
            if (avail_lvl[0]) begin
                pop_lvl[0] = 1'b1;
                sel_src    = SRC_FIFO;
            end else if (avail_lvl[1]) begin
                pop_lvl[1] = 1'b1;
                sel_src    = SRC_FIFO;
            end else if (avail_lvl[2]) begin
                pop_lvl[2] = 1'b1;
                sel_src    = SRC_FIFO;
            end else if (stack_cnt_pushed != '0) begin
                sel_src = SRC_STACK;
            end
        end
        stack_pop = (sel_src == SRC_STACK);

        // Running slot update.
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        case (sel_src)
            SRC_FIFO: begin
                run_valid_next = 1'b1;
                if (pop_lvl[0]) begin
                    run_id_next   = head_val[0];
                    run_prio_next = 2'd0;
                end else if (pop_lvl[1]) begin
                    run_id_next   = head_val[1];
                    run_prio_next = 2'd1;
                end else begin
                    run_id_next   = head_val[2];
                    run_prio_next = 2'd2;
                end
            end
            SRC_STACK: begin
                run_valid_next = 1'b1;
                run_id_next    = stack_top[ID_WIDTH-1:0];
                run_prio_next  = stack_top[SEW-1:ID_WIDTH];
            end
            default: begin
                if (do_sel) begin
                    run_valid_next = 1'b0;
                end
            end
        endcase

        // The resume flag follows only the selection made on a tick.
        resume_next = resume_reg;
        if (in_kind == KIND_TICK) begin
            case (sel_src)
                SRC_STACK: resume_next = 1'b1;
                SRC_NONE:  resume_next = 1'b0;
                default:   resume_next = resume_reg;
            endcase
        end

        // Pointer and count updates; the read port is steered to the next head.
        for (int l = 0; l < PTS_LEVELS; l++) begin
            head_inc[l] = (head_reg[l] == QIW'(QUEUE_DEPTH - 1)) ? '0
                          : head_reg[l] + QIW'(1);
            count_next[l] = count_reg[l];
            head_next[l]  = head_reg[l];
            if (s_fire) begin
                count_next[l] = count_reg[l] + CW'(wr_lvl[l]) - CW'(pop_lvl[l]);
                head_next[l]  = pop_lvl[l] ? head_inc[l] : head_reg[l];
            end
            fifo_raddr[l] = head_next[l];
        end

        stack_cnt_next = stack_cnt_reg;
        if (s_fire) begin
            stack_cnt_next = stack_cnt_pushed - SCW'(stack_pop);
        end
        stack_top_cnt = stack_cnt_next - SCW'(1);
        stack_raddr   = stack_top_cnt[SIW-1:0];

        // Pack the result word.
        comp_id_ext   = {{PTS_PORT_ID_W{1'b0}}, completed_id};
        comp_id_port  = comp_id_ext[PTS_PORT_ID_W-1:0];
        run_id_ext    = {{PTS_PORT_ID_W{1'b0}}, run_id_next};
        run_id_port   = run_valid_next ? run_id_ext[PTS_PORT_ID_W-1:0] : '0;
        run_prio_port = run_valid_next ? run_prio_next : 2'd0;
        m_data_next   = {2'b00, resume_next, run_prio_port, run_id_port, run_valid_next,
                         comp_id_port, completed_valid,
                         wr_lvl[0] || wr_lvl[1] || wr_lvl[2]};
    end

    // Scheduler state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < PTS_LEVELS; l++) begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            stack_cnt_reg <= '0;
            run_valid_reg <= 1'b0;
            resume_reg    <= 1'b0;
        end else begin
            for (int l = 0; l < PTS_LEVELS; l++) begin
                head_reg[l]  <= head_next[l];
                count_reg[l] <= count_next[l];
            end
            stack_cnt_reg <= stack_cnt_next;
            if (s_fire) begin
                run_valid_reg <= run_valid_next;
                resume_reg    <= resume_next;
            end
        end
    end

    // Running task payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            run_id_reg   <= run_id_next;
            run_prio_reg <= run_prio_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // The tasks held in FIFOs and on the stack never exceed the shared store size.
    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= TW'(SD))
        else $error("stored task count exceeds the store size");

    // No level FIFO holds more than its depth.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= CW'(QUEUE_DEPTH)) && (count_reg[1] <= CW'(QUEUE_DEPTH))
        && (count_reg[2] <= CW'(QUEUE_DEPTH)))
        else $error("level FIFO count exceeds its depth");

    // The resume flag is only raised by a pop from a non-empty stack.
    a_resume_from_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(resume_reg) |-> ($past(stack_cnt_reg) != '0))
        else $error("resume flag raised without a stacked task");

    // Scheduler state holds while no word is taken.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(stack_cnt_reg) && $stable(run_valid_reg)
                     && $stable(resume_reg)))
        else $error("scheduler state changed without an input word");

endmodule

// File: hdl/ptsched_ram.sv
// Simple dual-port storage with registered read and write-to-read bypass.
// Depends on nothing; used for the level FIFOs and the preemption stack.
module ptsched_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and a read that returns the word being written to the same address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
